FILE: rtl/core/lpvt_pkg.sv
package lpvt_pkg;

  localparam int NUM_VARS        = 4096;
  localparam int FRAC_BITS       = 32;
  localparam int VOTE_W          = 48;
  localparam int ADDR_W          = $clog2(NUM_VARS);
  localparam int IDX_W           = 12;
  localparam int SIZE_W          = 16;
  localparam int MAX_CLAUSE_SIZE = 63;
  localparam int WEIGHT_W        = FRAC_BITS + 2;
  localparam int SUM_W           = VOTE_W + 2;
  localparam int OUT_DEPTH       = 4;
  localparam int OUT_PTR_W       = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W       = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_CLAUSE = 2'd0,
    REQ_XOR    = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    CLASS_NEG  = 2'd0,
    CLASS_ZERO = 2'd1,
    CLASS_POS  = 2'd2
  } class_t;

  // One decoded item on its way to the vote memory.
  typedef struct packed {
    logic                       wr_en;
    logic                       is_read;
    logic [IDX_W-1:0]           idx;
    logic [ADDR_W-1:0]          addr;
    logic signed [WEIGHT_W-1:0] weight;
  } op_t;

  typedef struct packed {
    logic [IDX_W-1:0]         read_index;
    logic                     polarity;
    class_t                   vote_class;
    logic signed [VOTE_W-1:0] vote_value;
  } result_t;

endpackage

FILE: rtl/core/lpvt_decode.sv
module lpvt_decode (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  lpvt_pkg::req_t                    req,
  input  logic [lpvt_pkg::IDX_W-1:0]        var_index,
  input  logic                              lit_sign,
  input  logic [lpvt_pkg::SIZE_W-1:0]       clause_size,
  input  logic                              learnt_flag,
  output logic                              op_valid,
  output lpvt_pkg::op_t                     op
);

  localparam int SHIFT_W = $clog2(lpvt_pkg::FRAC_BITS + 1);

  // Weight 2^-(size-1) in stored units; zero when it falls out of range.
  function automatic logic signed [lpvt_pkg::WEIGHT_W-1:0] weight_of(
    input logic [lpvt_pkg::SIZE_W-1:0] size
  );
    logic [lpvt_pkg::SIZE_W-1:0] down;
    logic [SHIFT_W-1:0]          sh;
    down = size - lpvt_pkg::SIZE_W'(1);
    sh   = SHIFT_W'(lpvt_pkg::FRAC_BITS) - down[SHIFT_W-1:0];
    if (size == '0 || 32'(size) > lpvt_pkg::MAX_CLAUSE_SIZE ||
        32'(down) > lpvt_pkg::FRAC_BITS) begin
      return '0;
    end
    return lpvt_pkg::WEIGHT_W'(1) << sh;
  endfunction

  logic                                 in_range;
  logic signed [lpvt_pkg::WEIGHT_W-1:0] w;
  lpvt_pkg::op_t                        op_next;

  assign in_range = 32'(var_index) < lpvt_pkg::NUM_VARS;
  assign w        = weight_of(clause_size);

  always_comb begin
    op_next         = '0;
    op_next.idx     = var_index;
    op_next.addr    = lpvt_pkg::ADDR_W'(var_index);
    case (req)
      lpvt_pkg::REQ_CLAUSE: begin
        op_next.wr_en  = in_range && !learnt_flag;
        op_next.weight = lit_sign ? w : -w;
      end
      lpvt_pkg::REQ_XOR: begin
        op_next.wr_en  = in_range;
        op_next.weight = w;
      end
      lpvt_pkg::REQ_READ: begin
        op_next.wr_en   = in_range;
        op_next.is_read = 1'b1;
      end
      default: begin
        op_next.wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      op_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= op_next;
    end
  end

endmodule

FILE: rtl/core/lpvt_store.sv
module lpvt_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lpvt_pkg::ADDR_W-1:0] rd_addr,
  input  logic                        op_valid,
  input  lpvt_pkg::op_t               op,
  output logic                        clear_done,
  output logic                        res_valid,
  output lpvt_pkg::result_t           res
);

  localparam int VW = lpvt_pkg::VOTE_W;
  localparam int SW = lpvt_pkg::SUM_W;

  logic signed [VW-1:0] mem [lpvt_pkg::NUM_VARS];
  logic signed [VW-1:0] rdata;

  logic                        clearing;
  logic [lpvt_pkg::ADDR_W-1:0] clr_addr;

  logic                        lw_valid;
  logic [lpvt_pkg::ADDR_W-1:0] lw_addr;
  logic signed [VW-1:0]        lw_data;

  logic signed [VW-1:0] old;
  logic signed [SW-1:0] sum;
  logic signed [VW-1:0] sat;
  logic signed [VW-1:0] new_val;
  logic signed [VW-1:0] seen;
  logic                 we;
  logic [lpvt_pkg::ADDR_W-1:0] wa;
  logic signed [VW-1:0] wd;

  // The write of the previous cycle is not yet visible to a read issued in
  // that same cycle, so it is forwarded from the last-write register.
  assign old = (lw_valid && lw_addr == op.addr) ? lw_data : rdata;
  assign sum = SW'(old) + SW'(op.weight);

  always_comb begin
    if (!sum[SW-1] && sum[SW-2:VW-1] != '0) begin
      sat = {1'b0, {(VW-1){1'b1}}};
    end else if (sum[SW-1] && sum[SW-2:VW-1] != '1) begin
      sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat = sum[VW-1:0];
    end
  end

  assign new_val = op.is_read ? '0 : sat;
  assign we      = clearing || (op_valid && op.wr_en);
  assign wa      = clearing ? clr_addr : op.addr;
  assign wd      = clearing ? '0 : new_val;

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == lpvt_pkg::ADDR_W'(lpvt_pkg::NUM_VARS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + lpvt_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else begin
      lw_valid <= op_valid && op.wr_en;
    end
  end

  always_ff @(posedge clk) begin
    lw_addr <= op.addr;
    lw_data <= new_val;
  end

  assign clear_done = !clearing;

  // An index outside the store reads as a zero vote.
  assign seen = op.wr_en ? old : '0;

  always_comb begin
    res.read_index = op.idx;
    res.polarity   = !seen[VW-1];
    res.vote_value = seen;
    if (seen[VW-1]) begin
      res.vote_class = lpvt_pkg::CLASS_NEG;
    end else if (seen == '0) begin
      res.vote_class = lpvt_pkg::CLASS_ZERO;
    end else begin
      res.vote_class = lpvt_pkg::CLASS_POS;
    end
  end

  assign res_valid = op_valid && op.is_read;

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !op_valid)
    else $error("item in flight during clearing pass");

  a_read_clears_entry: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op.is_read && op.wr_en) |=> (lw_valid && lw_data == '0))
    else $error("read did not write back zero");

  a_outside_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !op.wr_en) |->
      (res.vote_value == '0 && res.vote_class == lpvt_pkg::CLASS_ZERO))
    else $error("read outside the store returned a nonzero vote");

endmodule

FILE: rtl/core/lpvt_out.sv
module lpvt_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpvt_pkg::result_t push_data,
  input  logic              inflight,
  input  logic              m_tready,
  output logic              m_tvalid,
  output lpvt_pkg::result_t pop_data,
  output logic              room
);

  lpvt_pkg::result_t q [lpvt_pkg::OUT_DEPTH];

  logic [lpvt_pkg::OUT_PTR_W-1:0] wr_ptr;
  logic [lpvt_pkg::OUT_PTR_W-1:0] rd_ptr;
  logic [lpvt_pkg::OUT_CNT_W-1:0] count;
  logic [lpvt_pkg::OUT_CNT_W-1:0] committed;
  logic                           pop;

  assign m_tvalid  = count != '0;
  assign pop       = m_tvalid && m_tready;
  assign pop_data  = q[rd_ptr];

  // A read in flight already owns a slot, so it counts against the room.
  assign committed = count + lpvt_pkg::OUT_CNT_W'(inflight);
  assign room      = committed < lpvt_pkg::OUT_CNT_W'(lpvt_pkg::OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lpvt_pkg::OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lpvt_pkg::OUT_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + lpvt_pkg::OUT_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - lpvt_pkg::OUT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != lpvt_pkg::OUT_CNT_W'(lpvt_pkg::OUT_DEPTH)))
    else $error("result pushed into a full output queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= lpvt_pkg::OUT_CNT_W'(lpvt_pkg::OUT_DEPTH))
    else $error("output queue count out of range");

endmodule

FILE: rtl/core/literal_polarity_vote_tally.sv
// Polarity vote tally: keeps one saturating signed Q15.32 vote per variable in a
// single-port-write memory and updates it with read-modify-write, one item per
// clock when the output side keeps up. An update or read is accepted, reads the
// memory in that cycle, and writes back in the next; the last write is forwarded
// so back-to-back items to the same variable see each other. A read result
// passes the op register and the output queue on its way to the master side. The
// output queue holds four results; s_tready drops when queued plus in-flight
// reads would fill it. After reset a clearing pass zeroes the memory one entry a
// cycle, all NUM_VARS (4096) entries, with s_tready held low throughout.
module literal_polarity_vote_tally (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [11:0] var_index, [12] lit_sign, [28:13] clause_size, [29] learnt_flag
  input  logic [31:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [11:0] read_index, [12] polarity, [14:13] vote_class, [62:15] vote_value
  output logic [63:0] m_tdata
);

  logic              accept;
  logic              clear_done;
  logic              room;
  logic              op_valid;
  lpvt_pkg::op_t     op;
  logic              res_valid;
  lpvt_pkg::result_t res;
  lpvt_pkg::result_t pop_data;

  assign s_tready = clear_done && room;
  assign accept   = s_tvalid && s_tready;

  lpvt_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req         (lpvt_pkg::req_t'(s_tuser)),
    .var_index   (s_tdata[11:0]),
    .lit_sign    (s_tdata[12]),
    .clause_size (s_tdata[28:13]),
    .learnt_flag (s_tdata[29]),
    .op_valid    (op_valid),
    .op          (op)
  );

  lpvt_store u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_addr    (lpvt_pkg::ADDR_W'(s_tdata[11:0])),
    .op_valid   (op_valid),
    .op         (op),
    .clear_done (clear_done),
    .res_valid  (res_valid),
    .res        (res)
  );

  lpvt_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .inflight  (res_valid),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .pop_data  (pop_data),
    .room      (room)
  );

  assign m_tdata = {1'b0, pop_data.vote_value, pop_data.vote_class,
                    pop_data.polarity, pop_data.read_index};

endmodule
